[sv/lfu_pkg.sv]
package lfu_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KEY_W     = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int STAMP_W   = 40;
    localparam int CAP_REG_W = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register word index (paddr[2])
    localparam logic CFG_CAPACITY_IDX = 1'b0;
    localparam logic [CAP_REG_W-1:0] CAPACITY_RESET = CAP_REG_W'(16);

    // Request kinds
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } lfu_state_t;

    typedef struct packed
    {
        logic load_req;
        logic scan_step;
        logic commit;
    } lfu_cmd_t;

    typedef struct packed
    {
        logic scan_done;
        logic out_free;
    } lfu_status_t;

endpackage

[sv/lfu_ctrl.sv]
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  lfu_status_t status,
    output lfu_cmd_t    cmd
);

    lfu_state_t state_reg;
    lfu_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                // commit once the scan is finished and the output slot is free
                if (status.scan_done && status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/lfu_datapath.sv]
module lfu_datapath
    import lfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfu_cmd_t             cmd,
    output lfu_status_t          status,
    input  logic                 in_opcode,
    input  logic [KEY_W-1:0]     in_key,
    input  logic [VALUE_W-1:0]   in_value,
    input  logic [CAP_REG_W-1:0] capacity,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_hit,
    output logic [VALUE_W-1:0]   out_read_value,
    output logic                 out_evicted,
    output logic [KEY_W-1:0]     out_evicted_key
);

    // Entry storage
    logic [KEY_BITS-1:0] key_mem   [CAPACITY];
    logic [VALUE_W-1:0]  value_mem [CAPACITY];
    logic [COUNT_W-1:0]  count_mem [CAPACITY];
    logic [STAMP_W-1:0]  stamp_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;

    logic [CNT_W-1:0]    occ_reg;
    logic [STAMP_W-1:0]  clock_reg;

    // Captured request
    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VALUE_W-1:0]  val_reg;

    // Scan pipeline
    logic [CNT_W-1:0]    cnt_reg;
    logic                pipe_vld_reg;
    logic [SLOT_W-1:0]   pipe_slot_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [VALUE_W-1:0]  rd_value_reg;
    logic [COUNT_W-1:0]  rd_count_reg;
    logic [STAMP_W-1:0]  rd_stamp_reg;

    // Match and victim trackers
    logic                found_reg;
    logic [SLOT_W-1:0]   found_slot_reg;
    logic [VALUE_W-1:0]  found_val_reg;
    logic [COUNT_W-1:0]  found_cnt_reg;
    logic                vic_reg;
    logic [SLOT_W-1:0]   vic_slot_reg;
    logic [KEY_BITS-1:0] vic_key_reg;
    logic [COUNT_W-1:0]  vic_cnt_reg;
    logic [STAMP_W-1:0]  vic_stamp_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_evicted_reg;
    logic [KEY_W-1:0]    out_evkey_reg;

    logic                issue;
    logic                entry_live;
    logic                key_match;
    logic                better;
    logic [CNT_W-1:0]    cap_eff;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_slot;
    logic [VALUE_W-1:0]  wr_value;
    logic [COUNT_W-1:0]  wr_count;
    logic                do_evict;
    logic                do_insert;

    assign issue = cmd.scan_step && (cnt_reg != CNT_W'(CAPACITY));

    // Memory read (one slot per cycle) and write at commit
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_key_reg   <= key_mem[cnt_reg[SLOT_W-1:0]];
            rd_value_reg <= value_mem[cnt_reg[SLOT_W-1:0]];
            rd_count_reg <= count_mem[cnt_reg[SLOT_W-1:0]];
            rd_stamp_reg <= stamp_mem[cnt_reg[SLOT_W-1:0]];
        end
        if (wr_en)
        begin
            key_mem[wr_slot]   <= key_reg;
            value_mem[wr_slot] <= wr_value;
            count_mem[wr_slot] <= wr_count;
            stamp_mem[wr_slot] <= clock_reg;
        end
    end

    // Scan counter and read pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_slot_reg <= '0;
        end
        else
        begin
            pipe_vld_reg <= issue;
            if (cmd.load_req)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg       <= cnt_reg + CNT_W'(1);
                pipe_slot_reg <= cnt_reg[SLOT_W-1:0];
            end
        end
    end

    assign status.scan_done = (cnt_reg == CNT_W'(CAPACITY)) && !pipe_vld_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // Compare the entry just read
    assign entry_live = pipe_vld_reg && valid_reg[pipe_slot_reg];
    assign key_match  = entry_live && !found_reg && (rd_key_reg == key_reg);
    assign better     = entry_live &&
                        (!vic_reg || (rd_count_reg < vic_cnt_reg) ||
                         ((rd_count_reg == vic_cnt_reg) && (rd_stamp_reg < vic_stamp_reg)));

    // Request capture and tracker data for the match and the victim
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= in_opcode;
            key_reg <= in_key[KEY_BITS-1:0];
            val_reg <= in_value;
        end
        if (key_match)
        begin
            found_slot_reg <= pipe_slot_reg;
            found_val_reg  <= rd_value_reg;
            found_cnt_reg  <= rd_count_reg;
        end
        if (better)
        begin
            vic_slot_reg  <= pipe_slot_reg;
            vic_key_reg   <= rd_key_reg;
            vic_cnt_reg   <= rd_count_reg;
            vic_stamp_reg <= rd_stamp_reg;
        end
    end

    // Tracker flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            vic_reg   <= 1'b0;
        end
        else if (cmd.load_req)
        begin
            found_reg <= 1'b0;
            vic_reg   <= 1'b0;
        end
        else
        begin
            if (key_match)
            begin
                found_reg <= 1'b1;
            end
            if (better)
            begin
                vic_reg <= 1'b1;
            end
        end
    end

    // Effective capacity, clamped to the table size
    always_comb
    begin
        if (32'(capacity) > CAPACITY)
        begin
            cap_eff = CNT_W'(CAPACITY);
        end
        else
        begin
            cap_eff = CNT_W'(capacity);
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Commit decision
    always_comb
    begin
        wr_en     = 1'b0;
        wr_slot   = found_slot_reg;
        wr_value  = val_reg;
        wr_count  = (found_cnt_reg == '1) ? found_cnt_reg : found_cnt_reg + COUNT_W'(1);
        do_evict  = 1'b0;
        do_insert = 1'b0;
        if (op_reg == OP_GET)
        begin
            wr_value = found_val_reg;
            wr_en    = found_reg;
        end
        else if (cap_eff != '0)
        begin
            if (found_reg)
            begin
                wr_en = 1'b1;
            end
            else if ((occ_reg >= cap_eff) && vic_reg)
            begin
                do_evict = 1'b1;
                wr_en    = 1'b1;
                wr_slot  = vic_slot_reg;
                wr_count = COUNT_W'(1);
            end
            else if (free_found)
            begin
                do_insert = 1'b1;
                wr_en     = 1'b1;
                wr_slot   = free_slot;
                wr_count  = COUNT_W'(1);
            end
        end
        wr_en     = wr_en && cmd.commit;
        do_evict  = do_evict && cmd.commit;
        do_insert = do_insert && cmd.commit;
    end

    // Valid bits, occupancy and use clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            clock_reg <= '0;
        end
        else
        begin
            if (do_insert)
            begin
                valid_reg[wr_slot] <= 1'b1;
                occ_reg            <= occ_reg + CNT_W'(1);
            end
            if (wr_en)
            begin
                clock_reg <= clock_reg + STAMP_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg     <= found_reg;
            out_value_reg   <= ((op_reg == OP_GET) && found_reg) ? found_val_reg : '0;
            out_evicted_reg <= do_evict;
            out_evkey_reg   <= do_evict ? KEY_W'(vic_key_reg) : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_hit         = out_hit_reg;
    assign out_read_value  = out_value_reg;
    assign out_evicted     = out_evicted_reg;
    assign out_evicted_key = out_evkey_reg;

endmodule

[sv/lfu_cache_table.sv]
// Channel   | Dir | Fields (low bit up)
// s_axis    | in  | tdata: lookup_key[15:0], store_value[47:16]; tuser: opcode
// m_axis    | out | tdata: read_value[31:0], evicted_key[47:32]; tuser: hit, evicted
// apb       | in  | reg 0 @ 0x0: capacity_in_use[4:0]
//
// A request is accepted in ST_IDLE; ST_SCAN then reads all 16 table slots, one slot per
// cycle, through the entry memory read port, drains the read register and commits, writing
// the slot; only after the commit is the next request accepted.
// The result sits in an output register; a stalled m_axis holds the commit only.
// Reset clears valid bits, occupancy and the use clock; capacity resets to 16.
module lfu_cache_table
    import lfu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,   // lookup_key, store_value
    input  logic [0:0]         s_axis_tuser,   // opcode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata,   // read_value, evicted_key
    output logic [1:0]         m_axis_tuser,   // hit, evicted
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    lfu_cmd_t               cmd;
    lfu_status_t            status;
    logic [CAP_REG_W-1:0]   capacity_reg;
    logic                   hit;
    logic                   evicted;
    logic [VALUE_W-1:0]     read_value;
    logic [KEY_W-1:0]       evicted_key;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == CFG_CAPACITY_IDX))
        begin
            capacity_reg <= pwdata[CAP_REG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_CAPACITY_IDX) ? PDATA_W'(capacity_reg) : '0;

    lfu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lfu_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_opcode       (s_axis_tuser[0]),
        .in_key          (s_axis_tdata[KEY_W-1:0]),
        .in_value        (s_axis_tdata[KEY_W+VALUE_W-1:KEY_W]),
        .capacity        (capacity_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_hit         (hit),
        .out_read_value  (read_value),
        .out_evicted     (evicted),
        .out_evicted_key (evicted_key)
    );

    assign m_axis_tdata = {evicted_key, read_value};
    assign m_axis_tuser = {evicted, hit};

endmodule

[sv/lfu_checker.sv]
module lfu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // No read data without a hit
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("read value nonzero on miss");

    // An eviction only happens on a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("eviction reported on hit");

    // Evicted key is zero when nothing was evicted
    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[47:32] == 16'd0)
        else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);
